[rtl/core/pip_pkg.sv]
// Shared types and constants for the point-in-polygon ray-cast block.
// Used by pip_ctrl, pip_datapath and the point_in_polygon_ray_cast top level.
`timescale 1ns / 1ps

package pip_pkg;

    // Default sizing of the vertex memory and of one coordinate.
    localparam int DEFAULT_MAX_VERTICES = 64;
    localparam int DEFAULT_COORD_BITS   = 16;

    // Fixed field widths of the streaming and configuration ports.
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int OPCODE_W = 1;

    // Vertex count after reset.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd3;

    // Item kinds carried in the input tuser.
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_vertex;  // write the input vertex at the memory address
        logic start_query;   // capture the query point and clear the parity
        logic rd_en;         // read one vertex at the memory address
        logic rd_first;      // the read fetches the first vertex of the walk
        logic load_result;   // copy the final parity into the result register
    } pip_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;     // an edge is still moving through the pipeline
    } pip_status_t;

endpackage

[rtl/core/point_in_polygon_ray_cast.sv]
// Even-odd point-in-polygon test by ray casting over a stored vertex table.
// A vertex load is written to the memory on its transfer. A query with n >= 1 vertices in use
// reads n + 1 vertices, one a cycle from the single-port vertex memory, then drains a
// four-stage edge pipeline and loads the result register; no new item is taken until the
// query is done. n is the count clamped to MAX_VERTICES; a count of zero skips the read walk.
// rst_n clears control state and sets the vertex count to three; the vertex memory
// is not cleared and holds no defined value until written.
`timescale 1ns / 1ps

module point_in_polygon_ray_cast #(
    parameter int MAX_VERTICES = pip_pkg::DEFAULT_MAX_VERTICES,
    parameter int COORD_BITS   = pip_pkg::DEFAULT_COORD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: vertex_index, coord_x, coord_y (from bit 0 up), zero padded to bytes.
    input  logic [((pip_pkg::INDEX_W + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: opcode.
    input  logic [pip_pkg::OPCODE_W-1:0]        s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: inside_res in bit 0, upper bits zero.
    output logic [7:0]                          m_tdata,
    // Configuration write of vertex_count.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pip_pkg::COUNT_W-1:0]         cfg_data
);
    import pip_pkg::*;

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int X_LO   = INDEX_W;
    localparam int Y_LO   = INDEX_W + COORD_BITS;

    logic [INDEX_W-1:0]           in_index;
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    pip_cmd_t                     cmd;
    pip_status_t                  status;
    logic [ADDR_W-1:0]            mem_addr;
    logic                         inside_res;

    // Unpack the input fields.
    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_x     = s_tdata[X_LO +: COORD_BITS];
    assign in_y     = s_tdata[Y_LO +: COORD_BITS];

    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser),
        .in_index  (in_index),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd),
        .mem_addr  (mem_addr)
    );

    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .mem_addr   (mem_addr),
        .in_x       (in_x),
        .in_y       (in_y),
        .status     (status),
        .inside_res (inside_res)
    );

    // Pack the result.
    assign m_tdata = {7'd0, inside_res};

endmodule

[rtl/core/pip_datapath.sv]
// Datapath: vertex memory, edge pipeline with exact cross-product test, parity.
// Depends on pip_pkg for the command and status structs.
`timescale 1ns / 1ps

module pip_datapath #(
    parameter int MAX_VERTICES = pip_pkg::DEFAULT_MAX_VERTICES,
    parameter int COORD_BITS   = pip_pkg::DEFAULT_COORD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pip_pkg::pip_cmd_t                   cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]     mem_addr,
    input  logic signed [COORD_BITS-1:0]        in_x,
    input  logic signed [COORD_BITS-1:0]        in_y,
    output pip_pkg::pip_status_t                status,
    output logic                                inside_res
);
    import pip_pkg::*;

    localparam int D_W    = COORD_BITS + 1;
    localparam int P_W    = 2 * D_W;
    localparam int DF_W   = P_W + 1;

    // Vertex memory, x in the low half and y in the high half of a word.
    logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
    logic [2*COORD_BITS-1:0] rd_data_reg;

    // Query point.
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;

    // Read stage control and the previous vertex of the walk.
    logic rd_v_reg;
    logic rd_first_reg;
    logic signed [COORD_BITS-1:0] cur_x;
    logic signed [COORD_BITS-1:0] cur_y;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;

    // Edge set-up stage.
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    logic in_range, early, early_val;
    logic b_v_reg, b_inr_reg, b_early_reg, b_early_val_reg, b_row_reg, b_lean_reg;
    logic signed [D_W-1:0] dx_reg, dpy_reg, dy_reg, dpx_reg;

    // Product stage.
    logic c_v_reg, c_inr_reg, c_early_reg, c_early_val_reg, c_row_reg, c_lean_reg;
    logic signed [P_W-1:0] p1_reg, p2_reg;

    // Decision stage.
    logic signed [DF_W-1:0] diff;
    logic crossed;
    logic parity_reg, parity_next;
    logic result_reg;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.write_vertex)
        begin
            mem[mem_addr] <= {in_y, in_x};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign cur_x = rd_data_reg[COORD_BITS-1:0];
    assign cur_y = rd_data_reg[2*COORD_BITS-1:COORD_BITS];

    // Order the edge ends by y; on equal y the end vertex is the lower one.
    always_comb
    begin
        if (prev_y_reg < cur_y)
        begin
            ax = prev_x_reg;
            ay = prev_y_reg;
            bx = cur_x;
            by = cur_y;
        end
        else
        begin
            ax = cur_x;
            ay = cur_y;
            bx = prev_x_reg;
            by = prev_y_reg;
        end
    end

    // Band test and the cases settled by the x extent of the edge.
    always_comb
    begin
        in_range  = (py_reg >= ay) && (py_reg < by);
        early     = 1'b0;
        early_val = 1'b0;
        if (ax > bx)
        begin
            if (px_reg > ax)
            begin
                early = 1'b1;
            end
            else if (px_reg < bx)
            begin
                early     = 1'b1;
                early_val = 1'b1;
            end
        end
        else
        begin
            if (px_reg > bx)
            begin
                early = 1'b1;
            end
            else if (px_reg < ax)
            begin
                early     = 1'b1;
                early_val = 1'b1;
            end
        end
    end

    // Sign of the cross product; a zero on the lower end's row uses the lean.
    always_comb
    begin
        diff = DF_W'(p1_reg) - DF_W'(p2_reg);
        if (c_early_reg)
        begin
            crossed = c_inr_reg && c_early_val_reg;
        end
        else if ((diff == '0) && c_row_reg)
        begin
            crossed = c_inr_reg && c_lean_reg;
        end
        else
        begin
            crossed = c_inr_reg && !diff[DF_W-1];
        end
    end

    always_comb
    begin
        parity_next = parity_reg;
        if (cmd.start_query)
        begin
            parity_next = 1'b0;
        end
        else if (c_v_reg && crossed)
        begin
            parity_next = ~parity_reg;
        end
    end

    // Pipeline control and parity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg     <= 1'b0;
            rd_first_reg <= 1'b0;
            b_v_reg      <= 1'b0;
            c_v_reg      <= 1'b0;
            parity_reg   <= 1'b0;
            result_reg   <= 1'b0;
        end
        else
        begin
            rd_v_reg     <= cmd.rd_en;
            rd_first_reg <= cmd.rd_first;
            b_v_reg      <= rd_v_reg && !rd_first_reg;
            c_v_reg      <= b_v_reg;
            parity_reg   <= parity_next;
            if (cmd.load_result)
            begin
                result_reg <= parity_reg;
            end
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (rd_v_reg)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        b_inr_reg       <= in_range;
        b_early_reg     <= early;
        b_early_val_reg <= early_val;
        b_row_reg       <= (py_reg == ay);
        b_lean_reg      <= (bx >= ax);
        dx_reg          <= D_W'(bx) - D_W'(ax);
        dpy_reg         <= D_W'(py_reg) - D_W'(ay);
        dy_reg          <= D_W'(by) - D_W'(ay);
        dpx_reg         <= D_W'(px_reg) - D_W'(ax);
        c_inr_reg       <= b_inr_reg;
        c_early_reg     <= b_early_reg;
        c_early_val_reg <= b_early_val_reg;
        c_row_reg       <= b_row_reg;
        c_lean_reg      <= b_lean_reg;
        p1_reg          <= dx_reg * dpy_reg;
        p2_reg          <= dy_reg * dpx_reg;
    end

    assign status.pipe_busy = rd_v_reg || b_v_reg || c_v_reg;
    assign inside_res       = result_reg;

endmodule

[rtl/core/pip_ctrl.sv]
// Controller: handshakes, vertex count register and the edge walk sequencer.
// Depends on pip_pkg for opcodes, widths and the command and status structs.
`timescale 1ns / 1ps

module pip_ctrl #(
    parameter int MAX_VERTICES = pip_pkg::DEFAULT_MAX_VERTICES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pip_pkg::OPCODE_W-1:0]        in_opcode,
    input  logic [pip_pkg::INDEX_W-1:0]         in_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pip_pkg::COUNT_W-1:0]         cfg_data,
    input  pip_pkg::pip_status_t                status,
    output pip_pkg::pip_cmd_t                   cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]     mem_addr
);
    import pip_pkg::*;

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int IDX_CMP_W = (ADDR_W + 1 > INDEX_W) ? ADDR_W + 1 : INDEX_W;

    typedef enum logic [1:0] {
        IDLE,
        WALK,
        DRAIN
    } state_t;

    state_t state_reg;
    logic [COUNT_W-1:0] vertex_count_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   k_reg;
    logic               out_valid_reg;

    logic [CMP_W-1:0]     count_ext;
    logic [CMP_W-1:0]     max_ext;
    logic [CNT_W-1:0]     n_eff;
    logic [IDX_CMP_W-1:0] idx_ext;
    logic                 slot_ok;
    logic                 in_xfer;
    logic                 finish;

    // Edge count in use, clamped to the memory depth.
    always_comb
    begin
        count_ext = CMP_W'(vertex_count_reg);
        max_ext   = CMP_W'(MAX_VERTICES);
        if (count_ext > max_ext)
        begin
            n_eff = max_ext[CNT_W-1:0];
        end
        else
        begin
            n_eff = count_ext[CNT_W-1:0];
        end
    end

    assign idx_ext   = IDX_CMP_W'(in_index);
    assign slot_ok   = idx_ext < IDX_CMP_W'(MAX_VERTICES);
    assign in_ready  = (state_reg == IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign finish    = (state_reg == DRAIN) && !status.pipe_busy
                       && (!out_valid_reg || out_ready);

    // Commands and memory address for the current cycle.
    always_comb
    begin
        cmd.write_vertex = in_xfer && (in_opcode == OP_LOAD) && slot_ok;
        cmd.start_query  = in_xfer && (in_opcode == OP_QUERY);
        cmd.rd_en        = (state_reg == WALK);
        cmd.rd_first     = (state_reg == WALK) && (k_reg == '0);
        cmd.load_result  = finish;
        mem_addr         = '0;
        if (state_reg == WALK)
        begin
            if (k_reg != n_reg)
            begin
                mem_addr = k_reg[ADDR_W-1:0];
            end
        end
        else
        begin
            mem_addr = idx_ext[ADDR_W-1:0];
        end
    end

    // Sequencer state, walk counter, count register and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE;
            vertex_count_reg <= COUNT_RESET;
            n_reg            <= '0;
            k_reg            <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                vertex_count_reg <= cfg_data;
            end

            // The result register is freed by a transfer and refilled at the end of a query.
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (cmd.start_query)
                    begin
                        n_reg <= n_eff;
                        k_reg <= '0;
                        if (n_eff == '0)
                        begin
                            state_reg <= DRAIN;
                        end
                        else
                        begin
                            state_reg <= WALK;
                        end
                    end
                end
                WALK:
                begin
                    // Reads vertices 0 .. n-1, then vertex 0 again to close the polygon.
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == n_reg)
                    begin
                        state_reg <= DRAIN;
                    end
                end
                DRAIN:
                begin
                    if (finish)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

[test/tb_point_in_polygon_ray_cast.sv]
// Self-checking testbench for point_in_polygon_ray_cast: loads random polygons, casts queries
// at them and compares every inside/outside answer with an even-odd crossing predictor.
// Depends on pip_pkg and the point_in_polygon_ray_cast RTL only.
`timescale 1ns / 1ps

module tb_point_in_polygon_ray_cast;

    import pip_pkg::*;

    localparam int NUM_SLOTS   = 64;
    localparam int DATA_W      = ((INDEX_W + 32 + 7) / 8) * 8;
    localparam int DRAIN_WAIT  = NUM_SLOTS + 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 400;

    // Tracks the vertex table and count, and holds the answers still owed by the block.
    class polygon_scoreboard;
        bit signed [15:0] vert_x [NUM_SLOTS];
        bit signed [15:0] vert_y [NUM_SLOTS];
        bit [COUNT_W-1:0] vertex_count;
        bit               inside_expected [$];
        int               mismatches;

        function void set_count(bit [COUNT_W-1:0] value);
            vertex_count = value;
        endfunction

        // One edge test; the query row is nudged just above any equal vertex row.
        function bit edge_crosses(longint px, longint py, int i, int j);
            longint ax, ay, bx, by, lhs, rhs;
            if (vert_y[i] < vert_y[j])
            begin
                ax = vert_x[i]; ay = vert_y[i]; bx = vert_x[j]; by = vert_y[j];
            end
            else
            begin
                ax = vert_x[j]; ay = vert_y[j]; bx = vert_x[i]; by = vert_y[i];
            end
            if (py < ay || py >= by)
                return 1'b0;
            if (ax > bx)
            begin
                if (px > ax) return 1'b0;
                if (px < bx) return 1'b1;
            end
            else
            begin
                if (px > bx) return 1'b0;
                if (px < ax) return 1'b1;
            end
            // Exact sign of the cross product; zero counts as a crossing, but on the lower end's row the lean decides.
            lhs = (bx - ax) * (py - ay);
            rhs = (by - ay) * (px - ax);
            if (lhs == rhs && py == ay)
                return bx >= ax;
            return lhs >= rhs;
        endfunction

        function bit point_parity(bit signed [15:0] qx, bit signed [15:0] qy);
            int  n;
            int  j;
            bit  parity;
            n = (vertex_count > NUM_SLOTS) ? NUM_SLOTS : vertex_count;
            parity = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                j = (i + 1 == n) ? 0 : i + 1;
                if (edge_crosses(qx, qy, i, j))
                    parity = ~parity;
            end
            return parity;
        endfunction

        // Called for every accepted input transfer, in acceptance order.
        function void note_item(bit [OPCODE_W-1:0] op, bit [INDEX_W-1:0] slot,
                                bit signed [15:0] cx, bit signed [15:0] cy);
            if (op == OP_LOAD)
            begin
                vert_x[slot] = cx;
                vert_y[slot] = cy;
            end
            else
                inside_expected.push_back(point_parity(cx, cy));
        endfunction

        // Called for every accepted result transfer.
        function void check_inside(bit got);
            bit want;
            if (inside_expected.size() == 0)
            begin
                $error("inside_res: expected no result, got %0d", got);
                mismatches++;
                return;
            end
            want = inside_expected.pop_front();
            if (want != got)
            begin
                $error("inside_res: expected %0d, got %0d", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic [OPCODE_W-1:0]  s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data;

    polygon_scoreboard    board = new();
    bit                   idle_on;
    int                   items_sent;
    int                   cycles;

    point_in_polygon_ray_cast DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("point_in_polygon_ray_cast: mismatch");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none while idling is off.
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic int rand_coord(int span);
        if (span >= 32767)
            return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Result side: random stalls on m_tready, every result transfer checked.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_inside(m_tdata[0]);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (pick_gap() > 0)
            begin
                stall_left = pick_gap();
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // One input transfer; valid stays high across back-to-back items.
    task automatic send_item(bit [OPCODE_W-1:0] op, int slot, int cx, int cy);
        int gap;
        bit [15:0] x16;
        bit [15:0] y16;
        gap = pick_gap();
        x16 = cx[15:0];
        y16 = cy[15:0];
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(DATA_W - INDEX_W - 32){1'b0}}, y16, x16, slot[INDEX_W-1:0]};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_item(op, slot[INDEX_W-1:0], x16, y16);
        items_sent++;
    endtask

    // Waits for the block to go idle, then writes a new vertex count.
    task automatic write_count(int value);
        s_tvalid <= 1'b0;
        while (board.inside_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[COUNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_count(value[COUNT_W-1:0]);
    endtask

    // Loads a random polygon into the slots in use, then queries around it.
    task automatic run_phase(int count);
        int used;
        int span;
        int queries;
        int r;
        int v;
        used = (count > NUM_SLOTS) ? NUM_SLOTS : count;
        case ($urandom_range(2))
            0: span = 8;
            1: span = 300;
            default: span = 32767;
        endcase
        idle_on = ($urandom_range(3) != 0);
        write_count(count);
        for (int i = 0; i < used; i++)
            send_item(OP_LOAD, i, rand_coord(span), rand_coord(span));
        queries = $urandom_range(20, 8);
        for (int q = 0; q < queries; q++)
        begin
            r = $urandom_range(99);
            v = $urandom_range(NUM_SLOTS - 1);
            if (r < 10)
                // Stray load anywhere in the table.
                send_item(OP_LOAD, v, rand_coord(32767), rand_coord(32767));
            else if (r < 25)
                // Query exactly on a vertex.
                send_item(OP_QUERY, v, board.vert_x[v], board.vert_y[v]);
            else if (r < 40)
                // Query on the row of a vertex.
                send_item(OP_QUERY, v, rand_coord(span), board.vert_y[v]);
            else
                send_item(OP_QUERY, v, rand_coord(span), rand_coord(span));
        end
    endtask

    initial
    begin : stimulus
        int extreme_counts [6];
        extreme_counts = '{0, 1, 2, 64, 127, 65};
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_LOAD;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        board.set_count(COUNT_RESET);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every slot gets written before any query can read it.
        idle_on = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++)
            send_item(OP_LOAD, i, rand_coord(32767), rand_coord(32767));

        // Extreme triangle under the reset count of three, with a horizontal base.
        send_item(OP_LOAD, 0, -32768, -32768);
        send_item(OP_LOAD, 1, 32767, -32768);
        send_item(OP_LOAD, 2, 0, 32767);
        send_item(OP_QUERY, 63, 0, 0);
        send_item(OP_QUERY, 0, -32768, -32768);
        send_item(OP_QUERY, 0, 32767, -32768);
        send_item(OP_QUERY, 0, 0, 32767);
        send_item(OP_QUERY, 0, -32768, 32767);
        send_item(OP_QUERY, 0, 32767, 32767);
        send_item(OP_QUERY, 0, 0, -32768);
        send_item(OP_QUERY, 0, -1, -32767);
        send_item(OP_QUERY, 0, 32767, 0);
        send_item(OP_QUERY, 0, -16384, 0);
        send_item(OP_QUERY, 0, -16385, 0);

        // Counts below three and at or above the table first, then random counts.
        foreach (extreme_counts[k])
            run_phase(extreme_counts[k]);
        run_phase(3);
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(3))
                0: run_phase($urandom_range(127));
                1: run_phase($urandom_range(64, 3));
                default: run_phase($urandom_range(10, 3));
            endcase
        end

        s_tvalid <= 1'b0;
        while (board.inside_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.mismatches == 0 && board.inside_expected.size() == 0)
            $display("point_in_polygon_ray_cast: match");
        else
            $display("point_in_polygon_ray_cast: mismatch");
        $finish;
    end

endmodule

[point_in_polygon_ray_cast.f]
rtl/core/pip_pkg.sv
rtl/core/pip_datapath.sv
rtl/core/pip_ctrl.sv
rtl/core/point_in_polygon_ray_cast.sv
test/tb_point_in_polygon_ray_cast.sv
